// ----- rtl/frame_byte_rate_meter_assert.svh -----
// Assertion macros shared by the frame byte rate meter RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef FRAME_BYTE_RATE_METER_ASSERT_SVH
`define FRAME_BYTE_RATE_METER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define FRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/frm_pkg.sv -----
// Package for the frame byte rate meter: word types, widths, codes and
// the controller-to-datapath command and status structs. No dependencies.
package frm_pkg;

  // Width of the wrapping byte accumulator.
  localparam int BYTE_ACC_BITS = 48;

  // Rates and quotients are 32 bits wide.
  localparam int QUO_W = 32;
  localparam int CNT_W = $clog2(QUO_W);

  // Frame count times 1000 needs ten more bits than the count.
  localparam int FPS_DIVIDEND_W = QUO_W + 10;
  // Byte total times 1000 before the divide by 1024.
  localparam int BYTE_PROD_W = BYTE_ACC_BITS + 10;
  // Dividend width of the shared divider.
  localparam int DIV_W = (BYTE_ACC_BITS > FPS_DIVIDEND_W) ? BYTE_ACC_BITS : FPS_DIVIDEND_W;

  localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;

  // Operation codes of an input word.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_ROLL  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] frame_bytes;
    logic [31:0] now_ms;
  } frm_in_t;

  typedef struct packed {
    logic        rolled;
    logic [31:0] frames_per_second;
    logic [31:0] kib_per_second;
  } frm_out_t;

  typedef struct packed {
    logic acc_frame;   // add a frame to the counters
    logic arm;         // record the first window start
    logic div_fps;     // start the frame rate division
    logic div_kbps;    // store the frame rate, start the byte rate division
    logic commit;      // store the byte rate, clear counters, restart window
    logic load_out;    // load the output word register
    logic out_rolled;  // rolled flag of the output word
  } frm_cmd_t;

  typedef struct packed {
    logic unarmed;     // window start is zero
    logic elapsed;     // the roll time closes the window
    logic div_done;    // divider finished this cycle
  } frm_sts_t;

endpackage

// ----- rtl/frm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, saturating at 32 bits.
// Depends on frm_pkg for the dividend width.
module frm_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [frm_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]              divisor,
  output logic                     done,
  output logic [31:0]              quotient
);
  import frm_pkg::*;

  logic [31:0]      rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [31:0]      dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             sat_r, sat_nxt;
  logic [63:0]      hi_ext;
  logic [32:0]      trial;
  logic [32:0]      diff;

  // Upper dividend bits: a quotient overflows 32 bits when they reach the divisor.
  assign hi_ext = 64'(dividend >> QUO_W);
  assign trial  = {rem_r, quo_r[QUO_W-1]};
  assign diff   = trial - {1'b0, dvs_r};

  // Load on start, then shift in one quotient bit per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    if (start) begin
      sat_nxt  = hi_ext >= {32'd0, divisor};
      rem_nxt  = hi_ext[31:0];
      quo_nxt  = dividend[QUO_W-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data flops.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    sat_r <= sat_nxt;
  end

  assign done     = done_r;
  assign quotient = sat_r ? '1 : quo_r;

endmodule

// ----- rtl/frm_dpath.sv -----
// Datapath of the frame byte rate meter: counters, window start, rate
// registers, output word register and the shared divider. Uses frm_pkg, frm_div.
module frm_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  frm_pkg::frm_in_t  in_data,
  input  frm_pkg::frm_cmd_t cmd,
  output frm_pkg::frm_sts_t sts,
  output frm_pkg::frm_out_t out_data
);
  import frm_pkg::*;

  logic [15:0]              window_ms_r;
  logic [31:0]              frame_count_r, frame_count_nxt;
  logic [BYTE_ACC_BITS-1:0] byte_total_r, byte_total_nxt;
  logic [31:0]              window_start_r, window_start_nxt;
  logic [31:0]              last_fps_r, last_fps_nxt;
  logic [31:0]              last_kbps_r, last_kbps_nxt;
  logic [31:0]              now_r;
  logic [31:0]              span_r;
  frm_out_t                 out_data_r;

  logic [31:0]               span_now;
  logic [15:0]               win;
  logic [FPS_DIVIDEND_W-1:0] fc_ext, fps_prod;
  logic [BYTE_PROD_W-1:0]    bt_ext, byte_prod;
  logic [DIV_W-1:0]          div_dividend;
  logic [31:0]               div_divisor;
  logic                      div_start;
  logic                      div_done;
  logic [31:0]               div_quo;

  // Window check on the incoming roll time; a zero window acts as one ms.
  assign span_now    = in_data.now_ms - window_start_r;
  assign win         = (window_ms_r == 16'd0) ? 16'd1 : window_ms_r;
  assign sts.unarmed = (window_start_r == 32'd0);
  assign sts.elapsed = !span_now[31] && (span_now >= {16'd0, win});
  assign sts.div_done = div_done;

  // Times 1000 as 1024 - 16 - 8; the byte product drops ten bits for KiB.
  assign fc_ext    = FPS_DIVIDEND_W'(frame_count_r);
  assign fps_prod  = (fc_ext << 10) - (fc_ext << 4) - (fc_ext << 3);
  assign bt_ext    = BYTE_PROD_W'(byte_total_r);
  assign byte_prod = (bt_ext << 10) - (bt_ext << 4) - (bt_ext << 3);

  // Divider operand selection.
  assign div_start    = cmd.div_fps || cmd.div_kbps;
  assign div_dividend = cmd.div_fps ? DIV_W'(fps_prod)
                                    : DIV_W'(byte_prod[BYTE_PROD_W-1:10]);
  assign div_divisor  = cmd.div_fps ? span_now : span_r;

  frm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next values of the meter state.
  always_comb begin
    frame_count_nxt  = frame_count_r;
    byte_total_nxt   = byte_total_r;
    window_start_nxt = window_start_r;
    last_fps_nxt     = cmd.div_kbps ? div_quo : last_fps_r;
    last_kbps_nxt    = cmd.commit ? div_quo : last_kbps_r;
    if (cmd.acc_frame) begin
      frame_count_nxt = frame_count_r + {31'd0, (in_data.frame_bytes != 32'd0)};
      byte_total_nxt  = byte_total_r + BYTE_ACC_BITS'(in_data.frame_bytes);
    end
    if (cmd.arm) begin
      window_start_nxt = in_data.now_ms;
    end
    if (cmd.commit) begin
      frame_count_nxt  = '0;
      byte_total_nxt   = '0;
      window_start_nxt = now_r;
    end
  end

  // State registers and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r    <= WINDOW_MS_RESET;
      frame_count_r  <= '0;
      byte_total_r   <= '0;
      window_start_r <= '0;
      last_fps_r     <= '0;
      last_kbps_r    <= '0;
    end else begin
      if (cfg_valid) begin
        window_ms_r <= cfg_data;
      end
      frame_count_r  <= frame_count_nxt;
      byte_total_r   <= byte_total_nxt;
      window_start_r <= window_start_nxt;
      last_fps_r     <= last_fps_nxt;
      last_kbps_r    <= last_kbps_nxt;
    end
  end

  // Roll time, span and output word; payload only, no reset.
  always_ff @(posedge clk) begin
    if (cmd.div_fps) begin
      now_r  <= in_data.now_ms;
      span_r <= span_now;
    end
    if (cmd.load_out) begin
      out_data_r.rolled            <= cmd.out_rolled;
      out_data_r.frames_per_second <= last_fps_nxt;
      out_data_r.kib_per_second    <= last_kbps_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ----- rtl/frm_ctrl.sv -----
// Controller of the frame byte rate meter: handshakes, division sequencing
// and output valid. Uses frm_pkg and the assertion macro header.
`include "frame_byte_rate_meter_assert.svh"

module frm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  frm_pkg::frm_sts_t sts,
  output frm_pkg::frm_cmd_t cmd
);
  import frm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIVF = 2'd1;
  localparam logic [1:0] S_DIVK = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register is free when empty or taken this cycle.
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    cmd      = '0;
    st_nxt   = st_r;
    in_ready = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (in_op == OP_FRAME) begin
            cmd.acc_frame = 1'b1;
            cmd.load_out  = 1'b1;
          end else if (sts.unarmed) begin
            cmd.arm      = 1'b1;
            cmd.load_out = 1'b1;
          end else if (!sts.elapsed) begin
            cmd.load_out = 1'b1;
          end else begin
            cmd.div_fps = 1'b1;
            st_nxt      = S_DIVF;
          end
        end
      end
      S_DIVF: begin
        if (sts.div_done) begin
          cmd.div_kbps = 1'b1;
          st_nxt       = S_DIVK;
        end
      end
      S_DIVK: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          if (out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_rolled = 1'b1;
            st_nxt         = S_IDLE;
          end else begin
            st_nxt = S_HOLD;
          end
        end
      end
      // The rates are committed; the rolled word waits for the output register.
      S_HOLD: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_rolled = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, cleared when taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FRM_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "output word overwritten before taken")
  `FRM_ASSERT_NOW(a_done_in_div, sts.div_done, st_r == S_DIVF || st_r == S_DIVK, "divider finished outside a division")
  `FRM_ASSERT_NEXT(a_fps_to_kbps, st_r == S_DIVF && sts.div_done, st_r == S_DIVK, "byte rate division did not follow")
  `FRM_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_r, "rolled word not presented after commit")

endmodule

// ----- rtl/frame_byte_rate_meter.sv -----
// Frame byte rate meter: windowed frame and KiB-per-second meter.
//
// Input words (in_valid/in_ready/in_data) are either a frame, which adds its
// byte count to the byte total and counts a frame when nonzero, or a roll,
// which carries a millisecond time. The first roll after reset or after a
// window restart at time zero only arms the window. A later roll whose signed
// elapsed time reaches window_ms recomputes both rates, clears the counters
// and restarts the window. Every input word yields exactly one output word
// (out_valid/out_ready/out_data) with the rolled flag and the last rates.
// cfg_valid/cfg_data writes window_ms; cfg_ready is always high.
// Frames, arming rolls and rolls inside the window give their word in the
// cycle after acceptance. A roll that closes the window runs two divisions of
// 32 quotient bits each in turn on one radix-2 divider and gives its word when
// both are done, or later while the output register holds an untaken word.
// The meter takes one word at a time; the next word is taken once the result
// is in the output register and that register is empty or being read.
// A stalled receiver holds the output word and blocks further input words.
// Reset clears counters, window start and rates and sets window_ms to 1000.
// Uses frm_pkg, frm_ctrl, frm_dpath.
module frame_byte_rate_meter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  frm_pkg::frm_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frm_pkg::frm_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import frm_pkg::*;

  frm_cmd_t cmd;
  frm_sts_t sts;

  // The window register is writable in any cycle.
  assign cfg_ready = 1'b1;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  frm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for frame_byte_rate_meter: directed and random frame and roll words.
// Predicts every result word in a local rate model and checks it. Needs frm_pkg and the RTL.
module tb;
  import frm_pkg::*;

  localparam int TAIL_CYCLES = 100;   // wait after every word is answered
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all
  localparam int PRINT_LIMIT = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  frm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  frm_out_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  frame_byte_rate_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Words waiting to be sent and rate words waiting to come back.
  frm_in_t  word_q[$];
  frm_out_t rate_q[$];

  int words_queued = 0;
  int words_taken = 0;
  int mismatch_count = 0;
  int send_pct = 0;
  int recv_pct = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // Predicted meter state.
  logic [15:0]              pm_window;
  logic [31:0]              pm_frames;
  logic [BYTE_ACC_BITS-1:0] pm_bytes;
  logic [31:0]              pm_start;
  logic [31:0]              pm_fps;
  logic [31:0]              pm_kbps;

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one input word to the predicted state and returns the rate word it yields.
  function automatic frm_out_t meter_step(frm_in_t w);
    frm_out_t    r;
    logic [31:0] span;
    logic [31:0] win;
    logic [63:0] scaled;
    logic [63:0] fps_full;
    logic [63:0] kbps_full;
    r.rolled = 1'b0;
    if (w.operation == OP_FRAME) begin
      if (w.frame_bytes != 32'd0) pm_frames = pm_frames + 32'd1;
      pm_bytes = pm_bytes + BYTE_ACC_BITS'(w.frame_bytes);
    end else if (pm_start == 0) begin
      pm_start = w.now_ms;
    end else begin
      span = w.now_ms - pm_start;
      win = (pm_window == 0) ? 32'd1 : {16'd0, pm_window};
      // A negative signed span means the clock is behind the window start.
      if (!span[31] && span >= win) begin
        scaled = 64'(pm_bytes >> 10) * 64'd1000 + (64'(pm_bytes[9:0]) * 64'd1000) / 64'd1024;
        fps_full = (64'(pm_frames) * 64'd1000) / 64'(span);
        kbps_full = scaled / 64'(span);
        pm_fps = (fps_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fps_full[31:0];
        pm_kbps = (kbps_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kbps_full[31:0];
        pm_frames = '0;
        pm_bytes = '0;
        pm_start = w.now_ms;
        r.rolled = 1'b1;
      end
    end
    r.frames_per_second = pm_fps;
    r.kib_per_second = pm_kbps;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Monitor: takes config writes, checks result words, predicts accepted words.
  always @(posedge clk) begin : monitor
    frm_out_t want;
    if (!rst_n) begin
      pm_window = WINDOW_MS_RESET;
      pm_frames = '0;
      pm_bytes = '0;
      pm_start = '0;
      pm_fps = '0;
      pm_kbps = '0;
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) pm_window = cfg_data;
      if (out_valid && out_ready) begin
        if (rate_q.size() == 0) begin
          report_mismatch("result word with none expected, fps", '0, out_data.frames_per_second);
        end else begin
          want = rate_q.pop_front();
          if (out_data.rolled !== want.rolled)
            report_mismatch("rolled", 32'(want.rolled), 32'(out_data.rolled));
          if (out_data.frames_per_second !== want.frames_per_second)
            report_mismatch("frames_per_second", want.frames_per_second,
                            out_data.frames_per_second);
          if (out_data.kib_per_second !== want.kib_per_second)
            report_mismatch("kib_per_second", want.kib_per_second, out_data.kib_per_second);
        end
      end
      if (in_valid && in_ready) begin
        rate_q.push_back(meter_step(in_data));
        words_taken++;
      end
    end
  end

  // Driver: presents the next queued word, idling at random between words.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (word_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_frame(logic [31:0] bytes);
    frm_in_t w;
    w.operation = OP_FRAME;
    w.frame_bytes = bytes;
    w.now_ms = $urandom;
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_roll(logic [31:0] now);
    frm_in_t w;
    w.operation = OP_ROLL;
    w.frame_bytes = $urandom;
    w.now_ms = now;
    word_q.push_back(w);
    words_queued++;
  endtask

  // Waits until every queued word was taken and answered, then lets the meter settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (words_taken != words_queued || rate_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(logic [15:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Mostly frames with realistic sizes and rolls on a rising clock, plus odd times.
  task automatic random_words(int count, logic [15:0] window, ref logic [31:0] t);
    int unsigned win_eff;
    int unsigned pick;
    logic [31:0] now;
    win_eff = (window == 0) ? 1 : window;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 9))
          0: queue_frame('0);
          1: queue_frame($urandom);
          2: queue_frame(32'hFFFF_FFFF);
          default: queue_frame($urandom_range(1, 1500));
        endcase
      end else if (pick < 90) begin
        t = t + $urandom_range(0, 2 * win_eff);
        queue_roll(t);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            t = $urandom;
            queue_roll(t);
          end
          1: queue_roll(t - $urandom_range(1, 2 * win_eff));
          2: queue_roll(t + 32'h8000_0000 + $urandom_range(0, 3));
          default: queue_roll('0);
        endcase
      end
    end
  endtask

  task automatic random_phase(int count, logic [15:0] window, int s_pct, int r_pct);
    logic [31:0] t;
    set_window(window);
    send_pct = s_pct;
    recv_pct = r_pct;
    t = $urandom_range(1, 100000);
    random_words(count / 2, window, t);
    // The sender holds off until every result is back, then carries on.
    wait_idle();
    random_words(count - count / 2, window, t);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset window of 1000 ms.
    queue_frame(32'hFFFF_FFFF);
    queue_frame('0);                   // zero-byte frame counts nothing
    queue_roll('0);                    // time zero keeps the meter unarmed
    queue_roll(32'd100);               // arms the window
    queue_frame(32'd1);
    queue_roll(32'd600);
    queue_roll(32'd1099);              // one short of the window
    queue_roll(32'd1100);              // exactly the window
    queue_roll(32'd1095);              // clock behind the start
    queue_roll(32'd1100 + 32'h8000_0000);
    queue_roll(32'd1100 + 32'h7FFF_FFFF);
    queue_frame(32'd12345);
    queue_roll('0);                    // closes and restarts at zero, so unarmed again
    queue_roll(32'd5);
    queue_frame(32'hA5A5_A5A5);
    queue_frame(32'h5A5A_5A5A);

    // Smallest window: a one-millisecond span saturates the byte rate.
    set_window(16'd1);
    repeat (3) queue_frame(32'hFFFF_FFFF);
    queue_roll(32'd6);
    queue_roll(32'd6);

    // A zero window acts as one millisecond.
    set_window(16'd0);
    queue_frame(32'd7);
    queue_roll(32'd7);
    queue_roll(32'd7);

    random_phase(325, 16'hFFFF, 0, 0);
    random_phase(325, 16'($urandom_range(1, 200)), 88, 0);
    random_phase(325, WINDOW_MS_RESET, 0, 88);
    random_phase(325, 16'($urandom_range(1, 65535)), 30, 30);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/frm_pkg.sv
rtl/frm_div.sv
rtl/frm_dpath.sv
rtl/frm_ctrl.sv
rtl/frame_byte_rate_meter.sv
dv/tb.sv
